### rtl/core/aegu_pkg.sv
`timescale 1ns / 1ps
package aegu_pkg;

  // Data format
  localparam int DATA_W     = 16;
  localparam int FRAC       = 11;

  // Tanh table
  localparam int ENTRIES    = 256;
  localparam int ENTRY_LOG2 = $clog2(ENTRIES);
  localparam int IDX_W      = ENTRY_LOG2 + 1;   // addresses entries 0..ENTRIES
  localparam int Q_SHIFT    = 30;               // table entries are Q30
  localparam int TH_W       = Q_SHIFT + 1;
  localparam logic [TH_W-1:0] ONE_Q = {1'b1, {Q_SHIFT{1'b0}}};

  // Segment search: index = 2*m*ENTRIES / (3 * 2^SHF)
  localparam int SHF        = FRAC + 2;
  localparam int DIVISOR    = 3 << SHF;
  localparam int NUM_W      = DATA_W + ENTRY_LOG2 + 1;
  localparam int S_W        = NUM_W - SHF;
  localparam int R_W        = SHF + 2;          // remainder < 3 * 2^SHF

  // Neighbor entries differ by less than 2^30 * 4 / ENTRIES (tanh slope <= 1)
  localparam int DIFF_W     = Q_SHIFT + 3 - ENTRY_LOG2;
  localparam int PROD_W     = DIFF_W + R_W;
  localparam int PQ_W       = PROD_W - SHF;

  // Output scaling, Q20 gains
  localparam int K_W        = 21;
  localparam logic [K_W-1:0] K_FWD = 21'd1808794;  // 1.725
  localparam logic [K_W-1:0] K_DER = 21'd1205862;  // 1.15
  localparam int P_W        = K_W + TH_W;
  localparam int RND_SH     = 50 - FRAC;
  localparam logic [P_W:0] RND_HALF = {{P_W{1'b0}}, 1'b1} << (RND_SH - 1);
  localparam int RND_W      = P_W + 1 - RND_SH;
  localparam int WIDE_A     = (RND_W + 1 > DATA_W) ? RND_W + 1 : DATA_W;
  localparam int WIDE_W     = ((WIDE_A > FRAC + 1) ? WIDE_A : FRAC + 1) + 1;

  // Configuration
  localparam int MODE_W     = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ACT_MODE = CFG_ADDR_W'(0);

  localparam logic [MODE_W-1:0] MODE_TANH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELU   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd2;

  localparam logic FUNC_FWD   = 1'b0;
  localparam logic FUNC_DERIV = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] x;
  } item_t;

  typedef struct packed {
    logic                     func;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] x;
    logic [TH_W-1:0]          th;
  } tanh_res_t;

  typedef logic [ENTRIES:0][TH_W-1:0] rom_t;

  // Floor of n/d by shift and subtract; only used while building the table.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table of tanh(4*j/ENTRIES) in Q30, evaluated once at elaboration.
  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned a;
    longint unsigned cube;
    longint unsigned t;
    longint unsigned den;
    for (int j = 0; j <= ENTRIES; j++) begin
      a    = (64'(j) << 20) >> ENTRY_LOG2;
      cube = (((a * a) >> 30) * a) >> 30;
      t    = a - udiv64(cube, 64'd3);
      for (int k = 0; k < 12; k++) begin
        den = (64'd1 << 30) + ((t * t) >> 30);
        t   = udiv64(t << 31, den);
      end
      rom[j] = t[TH_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t TANH_ROM = build_rom();

  // Floor of v/3: reciprocal multiply, then one correction step.
  function automatic logic [31:0] div3(input logic [31:0] v);
    logic [63:0] p;
    logic [31:0] q;
    logic [31:0] r;
    p = {32'd0, v} * 64'h0000_0000_5555_5555;
    q = p[63:32];
    r = v - (q + {q[30:0], 1'b0});
    if (r >= 32'd3) begin
      q = q + 32'd1;
    end
    return q;
  endfunction

  // Clamp to the signed DATA_W range.
  function automatic logic [DATA_W-1:0] sat_y(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end
    if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

### rtl/core/aegu_cfg.sv
`timescale 1ns / 1ps
module aegu_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [aegu_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [aegu_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [aegu_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [aegu_pkg::MODE_W-1:0]       act_mode
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == aegu_pkg::ADDR_ACT_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      act_mode <= aegu_pkg::MODE_TANH;
    end else if (wr_en) begin
      act_mode <= pwdata[aegu_pkg::MODE_W-1:0];
    end
  end

  always_comb begin
    if (paddr == aegu_pkg::ADDR_ACT_MODE) begin
      prdata = aegu_pkg::APB_DATA_W'(act_mode);
    end else begin
      prdata = '0;
    end
  end

endmodule

### rtl/core/aegu_tanh.sv
`timescale 1ns / 1ps
module aegu_tanh (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  aegu_pkg::item_t     in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output aegu_pkg::tanh_res_t out_res
);

  // Stage A: capture
  logic                             a_v;
  aegu_pkg::item_t                  a_item;
  // Stage B: segment index and remainder
  logic                             b_v;
  aegu_pkg::item_t                  b_item;
  logic                             b_sat;
  logic [aegu_pkg::ENTRY_LOG2-1:0]  b_idx;
  logic [aegu_pkg::R_W-1:0]         b_r;
  // Stage C: table read and slope product
  logic                             c_v;
  aegu_pkg::item_t                  c_item;
  logic                             c_sat;
  logic [aegu_pkg::TH_W-1:0]        c_t0;
  logic [aegu_pkg::PROD_W-1:0]      c_prod;
  // Stage D: interpolated magnitude
  logic                             d_v;
  aegu_pkg::tanh_res_t              d_res;

  logic a_rdy, b_rdy, c_rdy, d_rdy;

  logic [aegu_pkg::DATA_W-1:0]      mag;
  logic [aegu_pkg::NUM_W-1:0]       num;
  logic [31:0]                      s_ext;
  logic [31:0]                      q_b;
  logic [31:0]                      rem_b;
  logic                             b_sat_next;
  logic [aegu_pkg::ENTRY_LOG2-1:0]  b_idx_next;
  logic [aegu_pkg::R_W-1:0]         b_r_next;

  logic [aegu_pkg::TH_W-1:0]        t0;
  logic [aegu_pkg::TH_W-1:0]        t1;
  logic [aegu_pkg::DIFF_W-1:0]      diff;
  logic [aegu_pkg::PROD_W-1:0]      c_prod_next;

  logic [aegu_pkg::PQ_W-1:0]        pq;
  logic [31:0]                      q_d;
  logic [aegu_pkg::TH_W-1:0]        th_next;

  assign d_rdy     = !d_v || out_ready;
  assign c_rdy     = !c_v || d_rdy;
  assign b_rdy     = !b_v || c_rdy;
  assign a_rdy     = !a_v || b_rdy;
  assign in_ready  = a_rdy;
  assign out_valid = d_v;
  assign out_res   = d_res;

  // Index = floor(m / 48) at default sizes, split as a shift and a divide by three.
  always_comb begin
    if (a_item.x[aegu_pkg::DATA_W-1]) begin
      mag = aegu_pkg::DATA_W'(0) - a_item.x;
    end else begin
      mag = a_item.x;
    end
    num        = aegu_pkg::NUM_W'(mag) << (aegu_pkg::ENTRY_LOG2 + 1);
    s_ext      = 32'(num[aegu_pkg::NUM_W-1:aegu_pkg::SHF]);
    q_b        = aegu_pkg::div3(s_ext);
    rem_b      = s_ext - (q_b + {q_b[30:0], 1'b0});
    b_sat_next = (q_b >= 32'(aegu_pkg::ENTRIES));
    b_idx_next = q_b[aegu_pkg::ENTRY_LOG2-1:0];
    b_r_next   = {rem_b[1:0], num[aegu_pkg::SHF-1:0]};
  end

  always_comb begin
    t0          = aegu_pkg::TANH_ROM[{1'b0, b_idx}];
    t1          = aegu_pkg::TANH_ROM[aegu_pkg::IDX_W'(b_idx) + aegu_pkg::IDX_W'(1)];
    diff        = aegu_pkg::DIFF_W'(t1 - t0);
    c_prod_next = aegu_pkg::PROD_W'(diff) * aegu_pkg::PROD_W'(b_r);
  end

  always_comb begin
    pq = c_prod[aegu_pkg::PROD_W-1:aegu_pkg::SHF];
    q_d = aegu_pkg::div3(32'(pq));
    if (c_sat) begin
      th_next = aegu_pkg::ONE_Q;
    end else begin
      th_next = c_t0 + aegu_pkg::TH_W'(q_d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v <= in_valid;
      end
      if (b_rdy) begin
        b_v <= a_v;
      end
      if (c_rdy) begin
        c_v <= b_v;
      end
      if (d_rdy) begin
        d_v <= c_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_item <= in_item;
    end
    if (b_rdy) begin
      b_item <= a_item;
      b_sat  <= b_sat_next;
      b_idx  <= b_idx_next;
      b_r    <= b_r_next;
    end
    if (c_rdy) begin
      c_item <= b_item;
      c_sat  <= b_sat;
      c_t0   <= t0;
      c_prod <= c_prod_next;
    end
    if (d_rdy) begin
      d_res.func <= c_item.func;
      d_res.mode <= c_item.mode;
      d_res.x    <= c_item.x;
      d_res.th   <= th_next;
    end
  end

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    b_v |-> (b_r < aegu_pkg::R_W'(aegu_pkg::DIVISOR)))
    else $error("segment remainder not below divisor");

  a_th_bounded: assert property (@(posedge clk) disable iff (rst)
    d_v |-> (d_res.th <= aegu_pkg::ONE_Q))
    else $error("tanh magnitude above one");

  a_sat_gives_one: assert property (@(posedge clk) disable iff (rst)
    (c_v && c_sat && d_rdy) |=> (d_res.th == aegu_pkg::ONE_Q))
    else $error("saturated segment did not give one");

endmodule

### rtl/core/aegu_scale.sv
`timescale 1ns / 1ps
module aegu_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  aegu_pkg::tanh_res_t         in_res,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [aegu_pkg::DATA_W-1:0] out_y
);

  // Stage E: square and operand select
  logic                              e_v;
  aegu_pkg::item_t                   e_item;
  logic [aegu_pkg::K_W-1:0]          e_k;
  logic [aegu_pkg::TH_W-1:0]         e_opnd;
  // Stage F: gain product
  logic                              f_v;
  aegu_pkg::item_t                   f_item;
  logic [aegu_pkg::P_W-1:0]          f_p;
  // Stage G: output register
  logic                              g_v;
  logic [aegu_pkg::DATA_W-1:0]       g_y;

  logic e_rdy, f_rdy, g_rdy;

  logic [2*aegu_pkg::TH_W-1:0]       sq_full;
  logic [aegu_pkg::TH_W-1:0]         sq;
  logic [aegu_pkg::TH_W-1:0]         one_minus;
  logic [aegu_pkg::P_W-1:0]          f_p_next;

  logic [aegu_pkg::P_W:0]            rnd_sum;
  logic [aegu_pkg::RND_W-1:0]        rnd;
  logic signed [aegu_pkg::WIDE_W-1:0] tanh_w;
  logic signed [aegu_pkg::WIDE_W-1:0] x_w;
  logic signed [aegu_pkg::WIDE_W-1:0] one_w;
  logic signed [aegu_pkg::WIDE_W-1:0] y_w;
  logic                              x_pos;
  logic                              is_deriv;

  assign g_rdy     = !g_v || out_ready;
  assign f_rdy     = !f_v || g_rdy;
  assign e_rdy     = !e_v || f_rdy;
  assign in_ready  = e_rdy;
  assign out_valid = g_v;
  assign out_y     = g_y;

  always_comb begin
    sq_full   = {{aegu_pkg::TH_W{1'b0}}, in_res.th} * {{aegu_pkg::TH_W{1'b0}}, in_res.th};
    sq        = sq_full[aegu_pkg::Q_SHIFT+aegu_pkg::TH_W-1:aegu_pkg::Q_SHIFT];
    one_minus = aegu_pkg::ONE_Q - sq;
  end

  assign f_p_next = {{aegu_pkg::TH_W{1'b0}}, e_k} * {{aegu_pkg::K_W{1'b0}}, e_opnd};

  // Round the magnitude, then apply the sign to a forward value only.
  always_comb begin
    rnd_sum  = {1'b0, f_p} + aegu_pkg::RND_HALF;
    rnd      = rnd_sum[aegu_pkg::P_W:aegu_pkg::RND_SH];
    is_deriv = (f_item.func == aegu_pkg::FUNC_DERIV);
    x_w      = aegu_pkg::WIDE_W'(f_item.x);
    one_w    = aegu_pkg::WIDE_W'(1) << aegu_pkg::FRAC;
    x_pos    = !f_item.x[aegu_pkg::DATA_W-1] && (f_item.x != '0);
    tanh_w   = aegu_pkg::WIDE_W'(rnd);
    if (!is_deriv && f_item.x[aegu_pkg::DATA_W-1]) begin
      tanh_w = -tanh_w;
    end
    unique case (f_item.mode)
      aegu_pkg::MODE_TANH: begin
        y_w = tanh_w;
      end
      aegu_pkg::MODE_RELU: begin
        if (!x_pos) begin
          y_w = '0;
        end else if (is_deriv) begin
          y_w = one_w;
        end else begin
          y_w = x_w;
        end
      end
      default: begin
        y_w = is_deriv ? one_w : x_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else begin
      if (e_rdy) begin
        e_v <= in_valid;
      end
      if (f_rdy) begin
        f_v <= e_v;
      end
      if (g_rdy) begin
        g_v <= f_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_rdy) begin
      e_item.func <= in_res.func;
      e_item.mode <= in_res.mode;
      e_item.x    <= in_res.x;
      if (in_res.func == aegu_pkg::FUNC_DERIV) begin
        e_k    <= aegu_pkg::K_DER;
        e_opnd <= one_minus;
      end else begin
        e_k    <= aegu_pkg::K_FWD;
        e_opnd <= in_res.th;
      end
    end
    if (f_rdy) begin
      f_item <= e_item;
      f_p    <= f_p_next;
    end
    if (g_rdy) begin
      g_y <= aegu_pkg::sat_y(y_w);
    end
  end

endmodule

### rtl/core/activation_eval_grad_unit.sv
`timescale 1ns / 1ps
// Channel  | Direction | Payload                          | Handshake
// s_*      | in        | tdata: x[15:0]; tuser: func[0]   | tvalid / tready
// m_*      | out       | tdata: y[15:0]                   | tvalid / tready
// APB      | in        | act_mode at byte address 0       | psel / penable, pready
//
// One item per cycle sustained while m_tready stays high; m_tvalid rises once the item
// has passed through the capture stage plus six more register stages of the tanh
// and scaling pipeline.
// Reset (rst, synchronous) clears every stage valid bit and sets act_mode to
// scaled tanh. A low m_tready holds the output register; bubbles still fill,
// and s_tready falls only once every stage holds an item.
module activation_eval_grad_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [aegu_pkg::DATA_W-1:0]       s_tdata,   // [15:0] x
  input  logic                              s_tuser,   // [0] func
  // Output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [aegu_pkg::DATA_W-1:0]       m_tdata,   // [15:0] y
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [aegu_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [aegu_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [aegu_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [aegu_pkg::MODE_W-1:0] act_mode;
  aegu_pkg::item_t             in_item;
  aegu_pkg::tanh_res_t         th_res;
  logic                        th_valid;
  logic                        th_ready;

  // User's job, unchecked: Mode only changes while the pipeline is empty. Tag on entry.
  assign in_item.func = s_tuser;
  assign in_item.mode = act_mode;
  assign in_item.x    = s_tdata;

  aegu_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .act_mode (act_mode)
  );

  // Capture, segment index, table read with slope product, interpolation.
  aegu_tanh u_tanh (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (th_valid),
    .out_ready (th_ready),
    .out_res   (th_res)
  );

  // Square, gain product, then round, select by mode and clamp into the output register.
  aegu_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (th_valid),
    .in_ready  (th_ready),
    .in_res    (th_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_y     (m_tdata)
  );

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule
